[design/g2e_pkg.sv]
`timescale 1ns / 1ps
// shared constants, types and the arctangent table function of the geodetic to ecef converter
package g2e_pkg;

    typedef logic signed [63:0] fx_t;

    localparam int CORDIC_STAGES_DEF = 24;
    localparam int MUL_LAT           = 3;
    localparam int NEWTON_STEPS      = 3;

    localparam int LAT_W    = 32;
    localparam int LON_W    = 32;
    localparam int HGT_W    = 28;
    localparam int OUT_W    = 34;
    localparam int IN_DATA_W  = 96;
    localparam int OUT_DATA_W = 104;

    localparam fx_t PI_Q60       = 64'sh3243F6A8885A308D;
    localparam fx_t KINV_Q60     = 64'sd700114967507363246;
    localparam fx_t E2_Q60       = 64'sd7718094650643698;
    localparam fx_t ONE_Q60      = 64'sh1000000000000000;
    localparam fx_t THREE_Q60    = 64'sh3000000000000000;
    localparam fx_t ONE_M_E2_Q60 = ONE_Q60 - E2_Q60;
    localparam fx_t A_MM         = 64'sd6378137000;

    // atan(2^-i) in q61, alternating series with each term truncated
    function automatic fx_t atan_q61(input int unsigned i);
        fx_t         sum;
        logic [63:0] term;
        int          e;
        sum = '0;
        if (i == 0)
        begin
            return PI_Q60 >>> 1;
        end
        for (int k = 0; k < 64; k++)
        begin
            e = 61 - int'(i) * (2 * k + 1);
            if (e >= 0)
            begin
                term = (64'd1 << e) / 64'(2 * k + 1);
                if ((k % 2) == 1)
                    sum = sum - fx_t'(term);
                else
                    sum = sum + fx_t'(term);
            end
        end
        return sum;
    endfunction

endpackage

[design/g2e_mul.sv]
`timescale 1ns / 1ps
// three-stage signed 64x64 multiply with rounded right shift and saturation
module g2e_mul #(
    parameter int SHIFT = 60
) (
    input  logic            clk,
    input  logic            en,
    input  g2e_pkg::fx_t    a,
    input  g2e_pkg::fx_t    b,
    output g2e_pkg::fx_t    p
);

    localparam logic [127:0] HALF = 128'd1 << (SHIFT - 1);

    logic [63:0]  a_u;
    logic [63:0]  b_u;
    logic [63:0]  ua_next;
    logic [63:0]  ub_next;
    logic [63:0]  ua_reg;
    logic [63:0]  ub_reg;
    logic         neg_a_reg;
    logic         neg_b_reg;
    logic [63:0]  p00_next;
    logic [63:0]  p01_next;
    logic [63:0]  p10_next;
    logic [63:0]  p11_next;
    logic [63:0]  p00_reg;
    logic [63:0]  p01_reg;
    logic [63:0]  p10_reg;
    logic [63:0]  p11_reg;
    logic [127:0] sum;
    logic [127:0] shifted;
    logic [63:0]  mag;
    logic [63:0]  p_next;
    logic [63:0]  p_reg;

    assign a_u     = a;
    assign b_u     = b;
    assign ua_next = a[63] ? (~a_u + 64'd1) : a_u;
    assign ub_next = b[63] ? (~b_u + 64'd1) : b_u;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ua_reg    <= ua_next;
            ub_reg    <= ub_next;
            neg_a_reg <= a[63] ^ b[63];
        end
    end

    // 32x32 partial products
    assign p00_next = ua_reg[31:0]  * ub_reg[31:0];
    assign p01_next = ua_reg[31:0]  * ub_reg[63:32];
    assign p10_next = ua_reg[63:32] * ub_reg[31:0];
    assign p11_next = ua_reg[63:32] * ub_reg[63:32];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p00_reg   <= p00_next;
            p01_reg   <= p01_next;
            p10_reg   <= p10_next;
            p11_reg   <= p11_next;
            neg_b_reg <= neg_a_reg;
        end
    end

    assign sum = {64'd0, p00_reg} + {32'd0, p01_reg, 32'd0} + {32'd0, p10_reg, 32'd0}
               + {p11_reg, 64'd0} + HALF;
    assign shifted = sum >> SHIFT;
    assign mag     = (|shifted[127:63]) ? 64'h7FFF_FFFF_FFFF_FFFF : shifted[63:0];
    assign p_next  = neg_b_reg ? (~mag + 64'd1) : mag;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= p_next;
        end
    end

    assign p = g2e_pkg::fx_t'(p_reg);

endmodule

[design/g2e_dly.sv]
`timescale 1ns / 1ps
// fixed-depth payload delay line that advances with the pipeline
module g2e_dly #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1
) (
    input  logic             clk,
    input  logic             en,
    input  logic [WIDTH-1:0] din,
    output logic [WIDTH-1:0] dout
);

    logic [WIDTH-1:0] tap_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tap_reg[0] <= din;
            for (int j = 1; j < DEPTH; j++)
            begin
                tap_reg[j] <= tap_reg[j-1];
            end
        end
    end

    assign dout = tap_reg[DEPTH-1];

endmodule

[design/g2e_sincos.sv]
`timescale 1ns / 1ps
// quadrant fold, angle scaling and pipelined rotation cordic for sine and cosine
module g2e_sincos #(
    parameter int STAGES = g2e_pkg::CORDIC_STAGES_DEF
) (
    input  logic                clk,
    input  logic                en,
    input  logic signed [31:0]  ang,
    output g2e_pkg::fx_t        sin_val,
    output g2e_pkg::fx_t        cos_val
);

    logic signed [32:0] a33;
    logic signed [32:0] fold_next;
    logic               flip_next;
    logic signed [32:0] fold_reg;
    logic               flip_reg;
    logic [0:0]         flip_d;
    g2e_pkg::fx_t       z0;
    g2e_pkg::fx_t       x_reg [STAGES];
    g2e_pkg::fx_t       y_reg [STAGES];
    g2e_pkg::fx_t       z_reg [STAGES];
    g2e_pkg::fx_t       sin_reg;
    g2e_pkg::fx_t       cos_reg;

    assign a33 = {ang[31], ang};

    always_comb
    begin
        fold_next = a33;
        flip_next = 1'b0;
        if (a33 > 33'sd1073741824)
        begin
            fold_next = a33 - 33'sd2147483648;
            flip_next = 1'b1;
        end
        else if (a33 < -33'sd1073741824)
        begin
            fold_next = a33 + 33'sd2147483648;
            flip_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fold_reg <= fold_next;
            flip_reg <= flip_next;
        end
    end

    // semicircles to q61 radians
    g2e_mul #(.SHIFT(30)) u_scale (
        .clk (clk),
        .en  (en),
        .a   ({{31{fold_reg[32]}}, fold_reg}),
        .b   (g2e_pkg::PI_Q60),
        .p   (z0)
    );

    g2e_dly #(.WIDTH(1), .DEPTH(g2e_pkg::MUL_LAT + STAGES)) u_flip_dly (
        .clk  (clk),
        .en   (en),
        .din  (flip_reg),
        .dout (flip_d)
    );

    for (genvar i = 0; i < STAGES; i++)
    begin : g_stage
        localparam g2e_pkg::fx_t ATAN = g2e_pkg::atan_q61(i);
        g2e_pkg::fx_t xi;
        g2e_pkg::fx_t yi;
        g2e_pkg::fx_t zi;
        if (i == 0)
        begin : g_first
            assign xi = g2e_pkg::KINV_Q60;
            assign yi = '0;
            assign zi = z0;
        end
        else
        begin : g_next
            assign xi = x_reg[i-1];
            assign yi = y_reg[i-1];
            assign zi = z_reg[i-1];
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!zi[63])
                begin
                    x_reg[i] <= xi - (yi >>> i);
                    y_reg[i] <= yi + (xi >>> i);
                    z_reg[i] <= zi - ATAN;
                end
                else
                begin
                    x_reg[i] <= xi + (yi >>> i);
                    y_reg[i] <= yi - (xi >>> i);
                    z_reg[i] <= zi + ATAN;
                end
            end
        end
    end

    // undo the half-turn fold
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sin_reg <= flip_d[0] ? -y_reg[STAGES-1] : y_reg[STAGES-1];
            cos_reg <= flip_d[0] ? -x_reg[STAGES-1] : x_reg[STAGES-1];
        end
    end

    assign sin_val = sin_reg;
    assign cos_val = cos_reg;

endmodule

[design/geodetic_to_ecef_top.sv]
`timescale 1ns / 1ps
// top level of the wgs84 geodetic to ecef converter
//
// One point enters per clock unless the output holds an untaken result. The pipeline is made
// up of the sine/cosine cordic (fold, scaling multiply, one stage per iteration) followed
// by the chain of pipelined multipliers that forms the inverse square root for the
// prime-vertical radius and scales it onto the three axes. The whole pipeline advances
// together and holds while a finished result is not taken.
module geodetic_to_ecef_top #(
    parameter int CORDIC_STAGES = g2e_pkg::CORDIC_STAGES_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // latitude [31:0], longitude [63:32], height_mm [91:64], zero padding
    input  logic [g2e_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // x_mm [33:0], y_mm [67:34], z_mm [101:68], zero padding
    output logic [g2e_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);

    localparam int ML      = g2e_pkg::MUL_LAT;
    localparam int NS      = g2e_pkg::NEWTON_STEPS;
    localparam int LS      = CORDIC_STAGES + ML + 2;
    localparam int T_Y0    = 2 * ML + 1;
    localparam int T_N     = T_Y0 + 3 * ML * NS;
    localparam int T_N20   = T_N + ML;
    localparam int T_T     = T_N20 + ML;
    localparam int T_XYZ   = T_T + ML;
    localparam int PIPE_D  = LS + T_XYZ + 1;

    logic                 en;
    logic [PIPE_D-1:0]    vld_reg;
    logic [PIPE_D-1:0]    vld_next;

    g2e_pkg::fx_t sp, cp, sl, cl;
    g2e_pkg::fx_t s2, es;
    g2e_pkg::fx_t w_reg, y0_reg;
    g2e_pkg::fx_t ny [NS+1];
    g2e_pkg::fx_t nw [NS];
    g2e_pkg::fx_t n20, nh, zr_m, zr, t;
    g2e_pkg::fx_t x1, y1, z1;
    g2e_pkg::fx_t cp_d, sp_d, sl_d, cl_d;
    g2e_pkg::fx_t h20a, h20b;
    logic [g2e_pkg::HGT_W-1:0] h_d;
    logic [g2e_pkg::OUT_W-1:0] x_reg, y_reg, z_reg;

    function automatic logic [g2e_pkg::OUT_W-1:0] rnd20(input logic [63:0] v);
        logic [64:0] mag;
        logic [64:0] r;
        logic [64:0] s;
        mag = v[63] ? ({1'b0, ~v} + 65'd1) : {1'b0, v};
        r   = (mag + (65'd1 << 19)) >> 20;
        s   = v[63] ? (~r + 65'd1) : r;
        return s[g2e_pkg::OUT_W-1:0];
    endfunction

    // whole pipeline moves unless the output holds an untaken result
    assign en            = !vld_reg[PIPE_D-1] || m_axis_tready;
    assign s_axis_tready = en;
    assign vld_next      = {vld_reg[PIPE_D-2:0], s_axis_tvalid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= vld_next;
    end

    g2e_sincos #(.STAGES(CORDIC_STAGES)) u_lat (
        .clk (clk), .en (en), .ang (s_axis_tdata[31:0]), .sin_val (sp), .cos_val (cp)
    );

    g2e_sincos #(.STAGES(CORDIC_STAGES)) u_lon (
        .clk (clk), .en (en), .ang (s_axis_tdata[63:32]), .sin_val (sl), .cos_val (cl)
    );

    g2e_mul #(.SHIFT(60)) u_s2 (.clk (clk), .en (en), .a (sp), .b (sp), .p (s2));
    g2e_mul #(.SHIFT(60)) u_es (.clk (clk), .en (en), .a (g2e_pkg::E2_Q60), .b (s2), .p (es));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            w_reg  <= g2e_pkg::ONE_Q60 - es;
            y0_reg <= g2e_pkg::ONE_Q60 + (es >>> 1);
        end
    end

    assign ny[0] = y0_reg;
    assign nw[0] = w_reg;

    // newton steps for 1/sqrt(w)
    for (genvar k = 0; k < NS; k++)
    begin : g_newton
        g2e_pkg::fx_t y2, w3, wy2, y6, corr;
        g2e_mul #(.SHIFT(60)) u_sq (.clk (clk), .en (en), .a (ny[k]), .b (ny[k]), .p (y2));
        g2e_dly #(.WIDTH(64), .DEPTH(ML)) u_w3 (.clk (clk), .en (en), .din (nw[k]), .dout (w3));
        g2e_mul #(.SHIFT(60)) u_wy (.clk (clk), .en (en), .a (w3), .b (y2), .p (wy2));
        g2e_dly #(.WIDTH(64), .DEPTH(2 * ML)) u_y6 (
            .clk (clk), .en (en), .din (ny[k]), .dout (y6)
        );
        assign corr = g2e_pkg::THREE_Q60 - wy2;
        g2e_mul #(.SHIFT(61)) u_up (.clk (clk), .en (en), .a (y6), .b (corr), .p (ny[k+1]));
        if (k < NS - 1)
        begin : g_wfwd
            g2e_dly #(.WIDTH(64), .DEPTH(2 * ML)) u_w6 (
                .clk (clk), .en (en), .din (w3), .dout (nw[k+1])
            );
        end
    end

    g2e_mul #(.SHIFT(40)) u_n20 (
        .clk (clk), .en (en), .a (g2e_pkg::A_MM), .b (ny[NS]), .p (n20)
    );

    g2e_dly #(.WIDTH(g2e_pkg::HGT_W), .DEPTH(LS + T_N20)) u_h_dly (
        .clk (clk), .en (en), .din (s_axis_tdata[91:64]), .dout (h_d)
    );
    assign h20a = {{(64 - g2e_pkg::HGT_W - 20){h_d[g2e_pkg::HGT_W-1]}}, h_d, 20'd0};
    g2e_dly #(.WIDTH(64), .DEPTH(ML)) u_h20_dly (.clk (clk), .en (en), .din (h20a), .dout (h20b));

    g2e_dly #(.WIDTH(64), .DEPTH(T_N20)) u_cp_dly (.clk (clk), .en (en), .din (cp), .dout (cp_d));
    g2e_dly #(.WIDTH(64), .DEPTH(T_T)) u_sp_dly (.clk (clk), .en (en), .din (sp), .dout (sp_d));
    g2e_dly #(.WIDTH(64), .DEPTH(T_T)) u_sl_dly (.clk (clk), .en (en), .din (sl), .dout (sl_d));
    g2e_dly #(.WIDTH(64), .DEPTH(T_T)) u_cl_dly (.clk (clk), .en (en), .din (cl), .dout (cl_d));

    assign nh = n20 + h20a;
    g2e_mul #(.SHIFT(60)) u_t (.clk (clk), .en (en), .a (nh), .b (cp_d), .p (t));
    g2e_mul #(.SHIFT(60)) u_zr (
        .clk (clk), .en (en), .a (n20), .b (g2e_pkg::ONE_M_E2_Q60), .p (zr_m)
    );
    assign zr = zr_m + h20b;

    g2e_mul #(.SHIFT(60)) u_x (.clk (clk), .en (en), .a (t), .b (cl_d), .p (x1));
    g2e_mul #(.SHIFT(60)) u_y (.clk (clk), .en (en), .a (t), .b (sl_d), .p (y1));
    g2e_mul #(.SHIFT(60)) u_z (.clk (clk), .en (en), .a (zr), .b (sp_d), .p (z1));

    // q20 mm down to mm
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg <= rnd20(x1);
            y_reg <= rnd20(y1);
            z_reg <= rnd20(z1);
        end
    end

    assign m_axis_tvalid = vld_reg[PIPE_D-1];
    assign m_axis_tdata  = {2'b00, z_reg, y_reg, x_reg};

    a_ready_follows_output: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("input ready does not follow output stall");

    a_stall_holds_valids: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vld_reg))
        else $error("valid bits moved during stall");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> vld_reg[0])
        else $error("accepted transaction not tracked");

    a_idle_bubble: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tvalid && en |=> !vld_reg[0])
        else $error("phantom transaction entered");

endmodule
